### rtl/bsqa_pkg.sv
package bsqa_pkg;

   // field widths
   localparam int SIZE_W  = 14;
   localparam int BYTES_W = 24;
   localparam int SLICE_W = 3;
   localparam int TIME_W  = 64;
   localparam int PRU_W   = 16;
   localparam int SUPPLY_W = 32;

   // number of slices the slice field can name
   localparam int SLICE_SPAN = 1 << SLICE_W;

   // supply quotient width: above this the supply always exceeds size plus mtu
   localparam int SUPPLY_QW = 15;

   // function codes
   localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
   localparam logic [1:0] FUNC_DEQUEUE = 2'd1;
   localparam logic [1:0] FUNC_SUPPLY  = 2'd2;
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;

   // packet types
   localparam logic [1:0] PKT_DATA  = 2'd0;
   localparam logic [1:0] PKT_ACK   = 2'd1;
   localparam logic [1:0] PKT_RELAY = 2'd2;
   localparam logic [1:0] PKT_OTHER = 2'd3;

   // verdict codes
   localparam logic [2:0] VERDICT_ACCEPTED       = 3'd0;
   localparam logic [2:0] VERDICT_DROPPED        = 3'd1;
   localparam logic [2:0] VERDICT_RELAY_ACCEPTED = 3'd2;
   localparam logic [2:0] VERDICT_DEQUEUED       = 3'd3;
   localparam logic [2:0] VERDICT_SUPPLY_UPDATED = 3'd4;

   // operation classes handed from front to back
   localparam logic [2:0] OP_ENQ_RELAY = 3'd0;
   localparam logic [2:0] OP_ENQ       = 3'd1;
   localparam logic [2:0] OP_DEQ_RELAY = 3'd2;
   localparam logic [2:0] OP_DEQ       = 3'd3;
   localparam logic [2:0] OP_SUPPLY    = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_QUEUE_LIMIT        = 2'd0;
   localparam logic [1:0] CSR_FEEDBACK_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_MTU_BYTES          = 2'd2;

   localparam logic [BYTES_W-1:0] QUEUE_LIMIT_RESET        = 24'd1048576;
   localparam logic [BYTES_W-1:0] FEEDBACK_THRESHOLD_RESET = 24'd60000;
   localparam logic [SIZE_W-1:0]  MTU_BYTES_RESET          = 14'd1500;

   // front to back queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef logic [FIFO_CNT_W-1:0] fifo_count_type;

   typedef struct packed {
      logic [BYTES_W-1:0] queue_limit;
      logic [BYTES_W-1:0] feedback_threshold;
      logic [SIZE_W-1:0]  mtu_bytes;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         op;
      logic [1:0]         pkt_type;
      logic [SIZE_W-1:0]  pkt_size;
      logic [SLICE_W-1:0] pkt_slice;
      logic [SLICE_W-1:0] tx_slice;
      logic               pslice_ok;
      logic               tslice_ok;
      logic               is_last;
      logic               is_first;
      logic               feedback_done;
      logic               inc_request;
      logic [SIZE_W-1:0]  supply_add;
   } item_type;

endpackage

### rtl/bsqa_front.sv
module bsqa_front #(
   parameter int NUM_SLICES  = 8,
   parameter int PS_PER_BYTE = 80
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [87:0]              req_tdata,
   input  logic [3:0]               req_tuser,
   input  bsqa_pkg::fifo_count_type queue_count,
   input  logic [13:0]              mtu_bytes,
   output logic                     push,
   output bsqa_pkg::item_type       push_item
);

   localparam int QW = bsqa_pkg::SUPPLY_QW;
   // elapsed time beyond which the supply quotient no longer matters
   localparam logic [63:0] BIG_PS = 64'(PS_PER_BYTE) << QW;
   localparam int XW = $clog2(BIG_PS);
   localparam int LW = $clog2(PS_PER_BYTE);
   localparam int SH = XW + LW;
   localparam int MW = XW + 1;
   localparam int PW = XW + MW;
   localparam logic [63:0] RECIP =
      ((64'd1 << SH) + 64'(PS_PER_BYTE) - 64'd1) / 64'(PS_PER_BYTE);
   localparam int OCC_W = bsqa_pkg::FIFO_CNT_W + 1;

   logic [1:0]  func;
   logic [63:0] timestamp;
   logic        accept;
   logic        load;
   logic [2:0]  op;
   logic [OCC_W-1:0] occupancy;

   logic                s1_v_ff, s1_v_in;
   bsqa_pkg::item_type  s1_item_ff, s1_item_in;
   logic [63:0]         s1_elapsed_ff, s1_elapsed_in;
   logic [63:0]         last_time_ff, last_time_in;

   logic                s2_v_ff;
   bsqa_pkg::item_type  s2_item_ff;
   logic [PW-1:0]       s2_prod_ff, s2_prod_in;
   logic                s2_big_ff, s2_big_in;

   logic [XW-1:0]       mul_a;
   logic [MW-1:0]       mul_b;
   logic [QW-1:0]       supply_q;
   logic [QW-1:0]       supply_diff;
   logic [13:0]         supply_add;

   assign func      = req_tuser[1:0];
   assign timestamp = req_tdata[87:24];

   // credit: everything in flight must find a queue entry
   assign occupancy  = OCC_W'(queue_count) + OCC_W'(s1_v_ff) + OCC_W'(s2_v_ff);
   assign req_tready = occupancy < OCC_W'(bsqa_pkg::FIFO_DEPTH);
   assign accept     = req_tvalid && req_tready;
   // the unused code is swallowed here
   assign load       = accept && (func != bsqa_pkg::FUNC_UNUSED);

   always_comb begin
      unique case (func)
         bsqa_pkg::FUNC_ENQUEUE: begin
            op = (req_tuser[3:2] == bsqa_pkg::PKT_RELAY) ? bsqa_pkg::OP_ENQ_RELAY
                                                          : bsqa_pkg::OP_ENQ;
         end
         bsqa_pkg::FUNC_DEQUEUE: begin
            op = (req_tuser[3:2] == bsqa_pkg::PKT_RELAY) ? bsqa_pkg::OP_DEQ_RELAY
                                                          : bsqa_pkg::OP_DEQ;
         end
         default: begin
            op = bsqa_pkg::OP_SUPPLY;
         end
      endcase
   end

   always_comb begin
      s1_item_in               = '0;
      s1_item_in.op            = op;
      s1_item_in.pkt_type      = req_tuser[3:2];
      s1_item_in.pkt_size      = req_tdata[13:0];
      s1_item_in.pkt_slice     = req_tdata[16:14];
      s1_item_in.tx_slice      = req_tdata[19:17];
      s1_item_in.pslice_ok     = 32'(req_tdata[16:14]) < NUM_SLICES;
      s1_item_in.tslice_ok     = 32'(req_tdata[19:17]) < NUM_SLICES;
      s1_item_in.is_last       = req_tdata[20];
      s1_item_in.is_first      = req_tdata[21];
      s1_item_in.feedback_done = req_tdata[22];
      s1_item_in.inc_request   = req_tdata[23];
   end

   assign s1_v_in       = load;
   assign s1_elapsed_in = timestamp - last_time_ff;
   assign last_time_in  = (load && func == bsqa_pkg::FUNC_SUPPLY) ? timestamp : last_time_ff;

   // floor(elapsed / PS_PER_BYTE) by reciprocal, exact for elapsed below BIG_PS
   assign mul_a      = s1_elapsed_ff[XW-1:0];
   assign mul_b      = RECIP[MW-1:0];
   assign s2_prod_in = PW'(mul_a) * PW'(mul_b);
   assign s2_big_in  = s1_elapsed_ff >= BIG_PS;

   assign supply_q    = s2_prod_ff[SH +: QW];
   assign supply_diff = supply_q - {1'b0, s2_item_ff.pkt_size};

   always_comb begin
      if (s2_big_ff) begin
         supply_add = mtu_bytes;
      end else if (supply_q > {1'b0, s2_item_ff.pkt_size}) begin
         supply_add = (supply_diff > {1'b0, mtu_bytes}) ? mtu_bytes : supply_diff[13:0];
      end else begin
         supply_add = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         last_time_ff <= '0;
      end else begin
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s1_v_ff;
         last_time_ff <= last_time_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff    <= s1_item_in;
      s1_elapsed_ff <= s1_elapsed_in;
      s2_item_ff    <= s1_item_ff;
      s2_prod_ff    <= s2_prod_in;
      s2_big_ff     <= s2_big_in;
   end

   assign push = s2_v_ff;

   always_comb begin
      push_item            = s2_item_ff;
      push_item.supply_add = supply_add;
   end

endmodule

### rtl/bsqa_queue.sv
module bsqa_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  bsqa_pkg::item_type       push_item,
   input  logic                     pop,
   output logic                     head_valid,
   output bsqa_pkg::item_type       head_item,
   output bsqa_pkg::fifo_count_type count
);

   bsqa_pkg::item_type mem_ff [bsqa_pkg::FIFO_DEPTH];
   logic [bsqa_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bsqa_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   bsqa_pkg::fifo_count_type        count_ff, count_in;

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_valid = count_ff != '0;
   assign head_item  = mem_ff[rd_ptr_ff];
   assign count      = count_ff;

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < bsqa_pkg::FIFO_CNT_W'(bsqa_pkg::FIFO_DEPTH)))
      else $error("queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue read while empty");

endmodule

### rtl/bsqa_back.sv
module bsqa_back #(
   parameter int NUM_SLICES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  bsqa_pkg::cfg_type  cfg,
   input  logic               head_valid,
   input  bsqa_pkg::item_type head_item,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [79:0]        rsp_tdata,
   output logic [2:0]         rsp_tuser
);

   localparam int SLICES_USED = (NUM_SLICES < bsqa_pkg::SLICE_SPAN) ? NUM_SLICES
                                                                    : bsqa_pkg::SLICE_SPAN;
   localparam int SIW = (SLICES_USED > 1) ? $clog2(SLICES_USED) : 1;

   logic [23:0] slice_ff [SLICES_USED];
   logic [SLICES_USED-1:0] nz_ff;
   logic [23:0] total_ff, total_in;
   logic [23:0] relay_ff, relay_in;
   logic [15:0] pru_ff, pru_in;
   logic [31:0] supply_ff, supply_in;
   logic [23:0] peak_ff, peak_in;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_verdict_ff, rsp_verdict_in;
   logic        rsp_efb_ff, rsp_efb_in;
   logic [23:0] rsp_fbytes_ff, rsp_fbytes_in;
   logic        rsp_granted_ff, rsp_granted_in;
   logic        rsp_service_ff, rsp_service_in;

   logic [SIW-1:0] pidx, tidx, addr;
   logic        is_deq, cur_ok, nz_t;
   logic [23:0] cur, size24, take, cur_less, total_take, relay_take;
   logic [24:0] sum_total, relay_sum;
   logic [32:0] supply_sum;
   logic        fits, fb_hit, pru_earn, ack_inc;
   logic        slice_we;
   logic [23:0] slice_wdata;
   logic [SLICES_USED-1:0] slice_nz_now;

   assign pop = head_valid && (!rsp_valid_ff || rsp_tready);

   assign pidx   = SIW'(head_item.pkt_slice);
   assign tidx   = SIW'(head_item.tx_slice);
   assign is_deq = head_item.op == bsqa_pkg::OP_DEQ;
   assign addr   = is_deq ? tidx : pidx;
   assign cur_ok = is_deq ? head_item.tslice_ok : head_item.pslice_ok;
   assign cur    = cur_ok ? slice_ff[addr] : '0;
   assign nz_t   = head_item.tslice_ok && nz_ff[tidx];
   assign size24 = 24'(head_item.pkt_size);

   assign sum_total  = {1'b0, total_ff} + 25'(head_item.pkt_size);
   assign fits       = head_item.pslice_ok && (sum_total <= {1'b0, cfg.queue_limit});
   assign relay_sum  = {1'b0, relay_ff} + 25'(head_item.pkt_size);
   assign take       = (size24 < cur) ? size24 : cur;
   assign cur_less   = cur - take;
   assign total_take = (take < total_ff) ? take : total_ff;
   assign relay_take = (size24 < relay_ff) ? size24 : relay_ff;
   assign supply_sum = {1'b0, supply_ff} + 33'(head_item.supply_add);

   assign fb_hit   = (head_item.pkt_type == bsqa_pkg::PKT_DATA) && !head_item.feedback_done
                     && (total_ff > cfg.feedback_threshold);
   assign pru_earn = (head_item.pkt_type == bsqa_pkg::PKT_DATA) && head_item.is_last
                     && !head_item.is_first;
   assign ack_inc  = (head_item.pkt_type == bsqa_pkg::PKT_ACK) && head_item.inc_request;

   always_comb begin
      total_in       = total_ff;
      relay_in       = relay_ff;
      pru_in         = pru_ff;
      supply_in      = supply_ff;
      peak_in        = peak_ff;
      slice_we       = 1'b0;
      slice_wdata    = cur;
      rsp_verdict_in = bsqa_pkg::VERDICT_ACCEPTED;
      rsp_efb_in     = 1'b0;
      rsp_fbytes_in  = '0;
      rsp_granted_in = 1'b0;
      rsp_service_in = 1'b0;
      unique case (head_item.op)
         bsqa_pkg::OP_ENQ_RELAY: begin
            relay_in       = relay_sum[24] ? 24'hFFFFFF : relay_sum[23:0];
            rsp_verdict_in = bsqa_pkg::VERDICT_RELAY_ACCEPTED;
            rsp_service_in = 1'b1;
         end
         bsqa_pkg::OP_ENQ: begin
            if (!fits) begin
               rsp_verdict_in = bsqa_pkg::VERDICT_DROPPED;
            end else begin
               if (fb_hit) begin
                  rsp_efb_in    = 1'b1;
                  rsp_fbytes_in = total_ff;
               end else if (pru_earn) begin
                  if (pru_ff != 16'hFFFF) begin
                     pru_in = pru_ff + 16'd1;
                  end
               end else if (ack_inc) begin
                  // spend a pru token first, then an mtu of supply
                  if (pru_ff != '0) begin
                     pru_in         = pru_ff - 16'd1;
                     rsp_granted_in = 1'b1;
                  end else if (supply_ff >= 32'(cfg.mtu_bytes)) begin
                     supply_in      = supply_ff - 32'(cfg.mtu_bytes);
                     rsp_granted_in = 1'b1;
                  end
               end
               slice_we    = 1'b1;
               slice_wdata = cur + size24;
               total_in    = sum_total[23:0];
               peak_in     = (sum_total[23:0] > peak_ff) ? sum_total[23:0] : peak_ff;
               // tx slice turns non-empty only if it is the slice being filled
               rsp_service_in = !nz_t && head_item.tslice_ok
                                && (head_item.pkt_slice == head_item.tx_slice)
                                && (head_item.pkt_size != '0);
            end
         end
         bsqa_pkg::OP_DEQ_RELAY: begin
            relay_in       = relay_ff - relay_take;
            rsp_verdict_in = bsqa_pkg::VERDICT_DEQUEUED;
            rsp_service_in = nz_t || (relay_in != '0);
         end
         bsqa_pkg::OP_DEQ: begin
            slice_we       = cur_ok;
            slice_wdata    = cur_less;
            total_in       = total_ff - total_take;
            rsp_verdict_in = bsqa_pkg::VERDICT_DEQUEUED;
            rsp_service_in = (cur_less != '0) || (relay_ff != '0);
         end
         bsqa_pkg::OP_SUPPLY: begin
            supply_in      = supply_sum[32] ? 32'hFFFFFFFF : supply_sum[31:0];
            rsp_verdict_in = bsqa_pkg::VERDICT_SUPPLY_UPDATED;
         end
         default: begin
            rsp_verdict_in = bsqa_pkg::VERDICT_ACCEPTED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLICES_USED; i++) begin
            slice_ff[i] <= '0;
         end
         nz_ff        <= '0;
         total_ff     <= '0;
         relay_ff     <= '0;
         pru_ff       <= '0;
         supply_ff    <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            if (slice_we) begin
               slice_ff[addr] <= slice_wdata;
               nz_ff[addr]    <= slice_wdata != '0;
            end
            total_ff  <= total_in;
            relay_ff  <= relay_in;
            pru_ff    <= pru_in;
            supply_ff <= supply_in;
            peak_ff   <= peak_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_verdict_ff <= rsp_verdict_in;
         rsp_efb_ff     <= rsp_efb_in;
         rsp_fbytes_ff  <= rsp_fbytes_in;
         rsp_granted_ff <= rsp_granted_in;
         rsp_service_ff <= rsp_service_in;
      end
   end

   // total and peak shown are the values after the beat was applied
   logic [23:0] rsp_total_ff, rsp_peak_ff;
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_total_ff <= total_in;
         rsp_peak_ff  <= peak_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_verdict_ff;
   assign rsp_tdata  = {5'd0, rsp_peak_ff, rsp_total_ff, rsp_service_ff,
                        rsp_granted_ff, rsp_fbytes_ff, rsp_efb_ff};

   always_comb begin
      for (int i = 0; i < SLICES_USED; i++) begin
         slice_nz_now[i] = slice_ff[i] != '0;
      end
   end

   a_peak_covers_total: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= total_ff)
      else $error("peak watermark below queued total");

   a_nonempty_bits_track: assert property (@(posedge clock) disable iff (reset)
      slice_nz_now == nz_ff)
      else $error("slice non-empty bits out of step with slice counts");

endmodule

### rtl/bolt_switch_queue_admission_top.sv
// path: front registers s1 and s2, front-to-back queue, back end result register
// throughput: one beat per cycle unless queue credit or rsp_tready holds the flow;
//   every event updates the counters as it is popped in the back end, and the supply
//   quotient comes from a pipelined reciprocal multiply in front
// reset: synchronous, clears all byte counts, tokens, sample time and watermark and
//   loads the register defaults; no clearing pass, the block is ready right after reset
module bolt_switch_queue_admission_top #(
   parameter int NUM_SLICES  = 8,
   parameter int PS_PER_BYTE = 80
) (
   input  logic        clock,
   input  logic        reset,
   // request beats
   input  logic        req_tvalid,
   output logic        req_tready,
   // pkt_size[13:0], pkt_slice[16:14], tx_slice[19:17], is_last[20], is_first[21],
   // feedback_done[22], inc_request[23], timestamp_ps[87:24]
   input  logic [87:0] req_tdata,
   // func[1:0], pkt_type[3:2]
   input  logic [3:0]  req_tuser,
   // result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // early_feedback[0], feedback_bytes[24:1], inc_granted[25], service_request[26],
   // total_bytes[50:27], peak_bytes[74:51], zero fill above
   output logic [79:0] rsp_tdata,
   // verdict[2:0]
   output logic [2:0]  rsp_tuser,
   // register writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   bsqa_pkg::cfg_type        cfg_ff, cfg_in;
   logic                     push;
   bsqa_pkg::item_type       push_item;
   logic                     pop;
   logic                     head_valid;
   bsqa_pkg::item_type       head_item;
   bsqa_pkg::fifo_count_type queue_count;

   // register file; the user must write it only while idle, the block does not enforce it
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            bsqa_pkg::CSR_QUEUE_LIMIT:        cfg_in.queue_limit        = csr_wdata;
            bsqa_pkg::CSR_FEEDBACK_THRESHOLD: cfg_in.feedback_threshold = csr_wdata;
            bsqa_pkg::CSR_MTU_BYTES:          cfg_in.mtu_bytes          = csr_wdata[13:0];
            default: begin
               // index beyond the register list is ignored
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.queue_limit        <= bsqa_pkg::QUEUE_LIMIT_RESET;
         cfg_ff.feedback_threshold <= bsqa_pkg::FEEDBACK_THRESHOLD_RESET;
         cfg_ff.mtu_bytes          <= bsqa_pkg::MTU_BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept, classify, sample clock bookkeeping and supply quotient
   bsqa_front #(
      .NUM_SLICES  (NUM_SLICES),
      .PS_PER_BYTE (PS_PER_BYTE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .queue_count (queue_count),
      .mtu_bytes   (cfg_ff.mtu_bytes),
      .push        (push),
      .push_item   (push_item)
   );

   // short queue decouples front from back; front issues on credit
   bsqa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .count      (queue_count)
   );

   // back: counter and token updates in order, result register
   bsqa_back #(
      .NUM_SLICES (NUM_SLICES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
